FILE: design/encoder_spi_read_sequencer_macros.svh
// assertion macros for the encoder read sequencer
// used by modules that check their own state; no other dependencies
`ifndef ENCODER_SPI_READ_SEQUENCER_MACROS_SVH
`define ENCODER_SPI_READ_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ESRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esrs check failed");
`define ESRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esrs check failed");
`else
`define ESRS_ASSERT_IMP(label, ante, cons)
`define ESRS_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: design/esrs_pkg.sv
// shared types and constants for the encoder read sequencer
// no dependencies
`timescale 1ns / 1ps

package esrs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMD0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CMD1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TWELVE = 3'd6;

  localparam logic [15:0] SETUP_RST = 16'd20;
  localparam logic [15:0] GAP_RST   = 16'd20;
  localparam logic [15:0] HOLD_RST  = 16'd24;
  localparam logic [15:0] IDLE_RST  = 16'd320;

  localparam logic [15:0] GOOD_MASK = 16'h3FFF;
  localparam logic [15:0] BAD_POS   = 16'hFFFF;
  localparam logic [15:0] ODD_BITS  = 16'h2AAA;
  localparam logic [15:0] EVEN_BITS = 16'h1555;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_BYTE  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_XFER0 = 3'd2,
    PH_GAP   = 3'd3,
    PH_XFER1 = 3'd4,
    PH_HOLD  = 3'd5,
    PH_REST  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] setup_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] idle_ticks;
    logic [7:0]  first_command;
    logic [7:0]  second_command;
    logic        twelve_bit_mode;
  } cfg_t;

  typedef struct packed {
    logic        select_active;
    logic        byte_request;
    logic [7:0]  tx_byte;
    logic        ready_res;
    logic        result_valid;
    logic [15:0] position;
    logic        parity_ok;
  } res_t;

endpackage

FILE: design/esrs_cfg.sv
// configuration register bank for the encoder read sequencer
// depends on esrs_pkg
`timescale 1ns / 1ps

module esrs_cfg import esrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks     <= SETUP_RST;
      cfg_r.gap_ticks       <= GAP_RST;
      cfg_r.hold_ticks      <= HOLD_RST;
      cfg_r.idle_ticks      <= IDLE_RST;
      cfg_r.first_command   <= '0;
      cfg_r.second_command  <= '0;
      cfg_r.twelve_bit_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP:  cfg_r.setup_ticks     <= cfg_wdata;
        REG_GAP:    cfg_r.gap_ticks       <= cfg_wdata;
        REG_HOLD:   cfg_r.hold_ticks      <= cfg_wdata;
        REG_IDLE:   cfg_r.idle_ticks      <= cfg_wdata;
        REG_CMD0:   cfg_r.first_command   <= cfg_wdata[7:0];
        REG_CMD1:   cfg_r.second_command  <= cfg_wdata[7:0];
        REG_TWELVE: cfg_r.twelve_bit_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/esrs_core.sv
// read sequencing state machine, tick timer and parity check
// depends on esrs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "encoder_spi_read_sequencer_macros.svh"

module esrs_core import esrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [1:0] action,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] last_position_r, last_position_nxt;
  logic        last_parity_ok_r, last_parity_ok_nxt;

  logic        is_tick, is_start, is_byte;
  logic [15:0] cnt_inc, limit;
  logic        wait_done;
  logic [15:0] word;
  logic        word_ok;
  logic [15:0] good_pos;

  assign is_tick  = (action == ACT_TICK);
  assign is_start = (action == ACT_START);
  assign is_byte  = (action == ACT_BYTE);

  // saturating tick counter and wait limit for the current phase
  assign cnt_inc = (tick_count_r != CNT_MAX) ? tick_count_r + 16'd1 : tick_count_r;

  always_comb begin
    case (phase_r)
      PH_SETUP: limit = cfg.setup_ticks;
      PH_GAP:   limit = cfg.gap_ticks;
      PH_HOLD:  limit = cfg.hold_ticks;
      PH_REST:  limit = cfg.idle_ticks;
      default:  limit = CNT_MAX;
    endcase
  end

  assign wait_done = (cnt_inc >= limit);

  // odd parity over alternate bits, high byte first
  assign word     = {high_byte_r, rx_byte};
  assign word_ok  = (word[15] == ~^(word & ODD_BITS)) && (word[14] == ~^(word & EVEN_BITS));
  assign good_pos = cfg.twelve_bit_mode ? ((word & GOOD_MASK) >> 2) : (word & GOOD_MASK);

  always_comb begin
    phase_nxt          = phase_r;
    tick_count_nxt     = tick_count_r;
    high_byte_nxt      = high_byte_r;
    last_position_nxt  = last_position_r;
    last_parity_ok_nxt = last_parity_ok_r;
    if (is_start) begin
      if (phase_r == PH_IDLE) begin
        phase_nxt      = PH_SETUP;
        tick_count_nxt = '0;
      end
    end else if (is_byte) begin
      if (phase_r == PH_XFER0) begin
        high_byte_nxt  = rx_byte;
        phase_nxt      = PH_GAP;
        tick_count_nxt = '0;
      end else if (phase_r == PH_XFER1) begin
        last_position_nxt  = word_ok ? good_pos : BAD_POS;
        last_parity_ok_nxt = word_ok;
        phase_nxt          = PH_HOLD;
        tick_count_nxt     = '0;
      end
    end else if (is_tick) begin
      case (phase_r)
        PH_SETUP, PH_GAP, PH_HOLD, PH_REST: begin
          tick_count_nxt = wait_done ? 16'd0 : cnt_inc;
          if (wait_done) begin
            case (phase_r)
              PH_SETUP: phase_nxt = PH_XFER0;
              PH_GAP:   phase_nxt = PH_XFER1;
              PH_HOLD:  phase_nxt = PH_REST;
              default:  phase_nxt = PH_IDLE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res               = '0;
    res.select_active = (phase_nxt == PH_SETUP) || (phase_nxt == PH_XFER0) ||
                        (phase_nxt == PH_GAP) || (phase_nxt == PH_XFER1) ||
                        (phase_nxt == PH_HOLD);
    res.ready_res     = (phase_nxt == PH_IDLE);
    res.position      = last_position_nxt;
    res.parity_ok     = last_parity_ok_nxt;
    if (is_tick && wait_done) begin
      case (phase_r)
        PH_SETUP: begin
          res.byte_request = 1'b1;
          res.tx_byte      = cfg.first_command;
        end
        PH_GAP: begin
          res.byte_request = 1'b1;
          res.tx_byte      = cfg.second_command;
        end
        default: ;
      endcase
    end
    res.result_valid = is_byte && (phase_r == PH_XFER1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      tick_count_r     <= '0;
      high_byte_r      <= '0;
      last_position_r  <= '0;
      last_parity_ok_r <= 1'b0;
    end else if (advance) begin
      phase_r          <= phase_nxt;
      tick_count_r     <= tick_count_nxt;
      high_byte_r      <= high_byte_nxt;
      last_position_r  <= last_position_nxt;
      last_parity_ok_r <= last_parity_ok_nxt;
    end
  end

  `ESRS_ASSERT_NXT(a_hold_when_idle, !advance, $stable(phase_r) && $stable(tick_count_r))
  `ESRS_ASSERT_NXT(a_req_enters_xfer, advance && res.byte_request,
                   (phase_r == PH_XFER0) || (phase_r == PH_XFER1))
  `ESRS_ASSERT_NXT(a_done_enters_hold, advance && res.result_valid, phase_r == PH_HOLD)
  `ESRS_ASSERT_IMP(a_good_pos_narrow, last_parity_ok_r, last_position_r[15:14] == 2'b00)

endmodule

FILE: design/encoder_spi_read_sequencer.sv
// top level of the encoder read sequencer: input beat register, core, result register
// depends on esrs_pkg, esrs_cfg and esrs_core
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: a time tick,
//   a start request or a byte-done with the received byte. Every input beat
//   gives exactly one result beat on the out_ channel (out_valid / out_stall)
//   holding chip select, byte request with its command byte, ready, result
//   valid and the last position with its parity flag.
//   The accepting edge loads the input register; the beat then moves through
//   the state machine into the result register.
//   Throughput is one beat per cycle unless the receiver stalls; the state machine
//   updates once per beat. The result register frees as it is taken, so a new beat
//   can be taken in the same cycle the previous result leaves.
//   When the receiver stalls, the result register holds, the input register
//   fills and then in_stall rises until the result is taken.
//   Synchronous reset (rst_n low) empties both registers, returns the state machine
//   to idle and loads the configuration defaults. Configuration is written through
//   cfg_we / cfg_index / cfg_wdata by the user while idle; the block does not check it.

module encoder_spi_read_sequencer import esrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_select_active,
  output logic                  out_byte_request,
  output logic [7:0]            out_tx_byte,
  output logic                  out_ready_res,
  output logic                  out_result_valid,
  output logic [15:0]           out_position,
  output logic                  out_parity_ok
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_r;
  logic       in_valid_r;
  logic [1:0] action_r;
  logic [7:0] rx_byte_r;
  logic       out_valid_r;
  logic       advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  esrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esrs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .action  (action_r),
    .rx_byte (rx_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      action_r  <= in_action;
      rx_byte_r <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_select_active = res_r.select_active;
  assign out_byte_request  = res_r.byte_request;
  assign out_tx_byte       = res_r.tx_byte;
  assign out_ready_res     = res_r.ready_res;
  assign out_result_valid  = res_r.result_valid;
  assign out_position      = res_r.position;
  assign out_parity_ok     = res_r.parity_ok;

endmodule

FILE: tb/testbench.sv
// testbench for encoder_spi_read_sequencer: directed and random event streams,
// each result beat checked against an in-bench model of the read sequence
// depends on esrs_pkg and the encoder_spi_read_sequencer rtl
`timescale 1ns / 1ps

module testbench;
  import esrs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int ROUND_EVENTS = 285;

  typedef struct packed {
    phase_t      ph;
    logic [15:0] ticks;
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    logic [15:0] pos;
    logic        ok;
  } read_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = '0;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_select_active;
  logic                  out_byte_request;
  logic [7:0]            out_tx_byte;
  logic                  out_ready_res;
  logic                  out_result_valid;
  logic [15:0]           out_position;
  logic                  out_parity_ok;

  cfg_t        timing_regs;
  read_state_t read_state;
  res_t        owed_reports[$];
  res_t        head_report;
  logic [15:0] read_word;
  int          failures = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  logic        idling_on = 1'b1;

  encoder_spi_read_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_select_active(out_select_active),
    .out_byte_request(out_byte_request),
    .out_tx_byte(out_tx_byte),
    .out_ready_res(out_ready_res),
    .out_result_valid(out_result_valid),
    .out_position(out_position),
    .out_parity_ok(out_parity_ok)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit tick_reaches(input logic [15:0] limit);
    if (read_state.ticks != CNT_MAX) read_state.ticks = read_state.ticks + 16'd1;
    return read_state.ticks >= limit;
  endfunction

  function automatic res_t advance_read_fsm(input logic [1:0] act, input logic [7:0] rx);
    res_t        r;
    logic [15:0] w;
    logic [15:0] p;
    r = '0;
    case (act)
      ACT_START: begin
        if (read_state.ph == PH_IDLE) begin
          read_state.ph = PH_SETUP;
          read_state.ticks = '0;
        end
      end
      ACT_BYTE: begin
        if (read_state.ph == PH_XFER0) begin
          read_state.hi_byte = rx;
          read_state.ph = PH_GAP;
          read_state.ticks = '0;
        end else if (read_state.ph == PH_XFER1) begin
          read_state.lo_byte = rx;
          w = {read_state.hi_byte, read_state.lo_byte};
          if (w[15] == ~^(w & ODD_BITS) && w[14] == ~^(w & EVEN_BITS)) begin
            p = w & GOOD_MASK;
            if (timing_regs.twelve_bit_mode) p = p >> 2;
            read_state.pos = p;
            read_state.ok = 1'b1;
          end else begin
            read_state.pos = BAD_POS;
            read_state.ok = 1'b0;
          end
          r.result_valid = 1'b1;
          read_state.ph = PH_HOLD;
          read_state.ticks = '0;
        end
      end
      ACT_TICK: begin
        case (read_state.ph)
          PH_SETUP: begin
            if (tick_reaches(timing_regs.setup_ticks)) begin
              read_state.ph = PH_XFER0;
              read_state.ticks = '0;
              r.byte_request = 1'b1;
              r.tx_byte = timing_regs.first_command;
            end
          end
          PH_GAP: begin
            if (tick_reaches(timing_regs.gap_ticks)) begin
              read_state.ph = PH_XFER1;
              read_state.ticks = '0;
              r.byte_request = 1'b1;
              r.tx_byte = timing_regs.second_command;
            end
          end
          PH_HOLD: begin
            if (tick_reaches(timing_regs.hold_ticks)) begin
              read_state.ph = PH_REST;
              read_state.ticks = '0;
            end
          end
          PH_REST: begin
            if (tick_reaches(timing_regs.idle_ticks)) begin
              read_state.ph = PH_IDLE;
              read_state.ticks = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.select_active = (read_state.ph >= PH_SETUP) && (read_state.ph <= PH_HOLD);
    r.ready_res = (read_state.ph == PH_IDLE);
    r.position = read_state.pos;
    r.parity_ok = read_state.ok;
    return r;
  endfunction

  function automatic logic [15:0] with_check_bits(input logic [15:0] w);
    logic [15:0] r;
    r = w;
    r[15] = ~^(w & ODD_BITS);
    r[14] = ~^(w & EVEN_BITS);
    return r;
  endfunction

  // receiver side: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      stall_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_reports.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
      end else begin
        head_report = owed_reports.pop_front();
        if (out_select_active !== head_report.select_active) begin
          $error("select_active: expected %0d, got %0d",
                 head_report.select_active, out_select_active);
          failures++;
        end
        if (out_byte_request !== head_report.byte_request) begin
          $error("byte_request: expected %0d, got %0d",
                 head_report.byte_request, out_byte_request);
          failures++;
        end
        if (out_tx_byte !== head_report.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", head_report.tx_byte, out_tx_byte);
          failures++;
        end
        if (out_ready_res !== head_report.ready_res) begin
          $error("ready_res: expected %0d, got %0d", head_report.ready_res, out_ready_res);
          failures++;
        end
        if (out_result_valid !== head_report.result_valid) begin
          $error("result_valid: expected %0d, got %0d",
                 head_report.result_valid, out_result_valid);
          failures++;
        end
        if (out_position !== head_report.position) begin
          $error("position: expected %0h, got %0h", head_report.position, out_position);
          failures++;
        end
        if (out_parity_ok !== head_report.parity_ok) begin
          $error("parity_ok: expected %0d, got %0d", head_report.parity_ok, out_parity_ok);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL encoder_spi_read_sequencer");
      $finish;
    end
  end

  task automatic send_event(input logic [1:0] act, input logic [7:0] rx);
    res_t want;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = advance_read_fsm(act, rx);
    owed_reports.push_back(want);
    @(negedge clk);
  endtask

  task automatic settle_block;
    in_valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SETUP:  timing_regs.setup_ticks = data;
      REG_GAP:    timing_regs.gap_ticks = data;
      REG_HOLD:   timing_regs.hold_ticks = data;
      REG_IDLE:   timing_regs.idle_ticks = data;
      REG_CMD0:   timing_regs.first_command = data[7:0];
      REG_CMD1:   timing_regs.second_command = data[7:0];
      REG_TWELVE: timing_regs.twelve_bit_mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] setup, input logic [15:0] gap,
                                input logic [15:0] hold, input logic [15:0] idle,
                                input logic [7:0] cmd0, input logic [7:0] cmd1,
                                input logic twelve);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_SETUP, setup);
    write_reg(REG_GAP, gap);
    write_reg(REG_HOLD, hold);
    write_reg(REG_IDLE, idle);
    write_reg(REG_CMD0, {junk[15:8], cmd0});
    write_reg(REG_CMD1, {junk[7:0], cmd1});
    write_reg(REG_TWELVE, {junk[15:1], twelve});
  endtask

  task automatic finish_read(input logic [15:0] word);
    while (read_state.ph != PH_IDLE) begin
      case (read_state.ph)
        PH_XFER0: send_event(ACT_BYTE, word[15:8]);
        PH_XFER1: send_event(ACT_BYTE, word[7:0]);
        default:  send_event(ACT_TICK, 8'($urandom));
      endcase
    end
  endtask

  task automatic do_read(input logic [15:0] word);
    send_event(ACT_START, 8'($urandom));
    finish_read(word);
  endtask

  task automatic random_event;
    logic [1:0] act;
    logic [7:0] rx;
    act = 2'($urandom_range(0, 3));
    rx = 8'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      case (read_state.ph)
        PH_IDLE: act = ACT_START;
        PH_XFER0: begin
          read_word = ($urandom_range(0, 3) != 0) ? with_check_bits(16'($urandom))
                                                  : 16'($urandom);
          act = ACT_BYTE;
          rx = read_word[15:8];
        end
        PH_XFER1: begin
          act = ACT_BYTE;
          rx = read_word[7:0];
        end
        default: act = ACT_TICK;
      endcase
    end
    send_event(act, rx);
  endtask

  task automatic test_default_settings;
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_BYTE, 8'hA5);
    send_event(ACT_UNUSED, 8'hFF);
    do_read(with_check_bits(16'h1234));
  endtask

  task automatic test_register_extremes;
    apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 8'h00, 8'h00, 1'b0);
    do_read(with_check_bits(16'h3FFF));
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 8'hFF, 1'b1);
    do_read(with_check_bits(16'h3FFF));
    do_read(16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    do_read(16'hFFFF);
  endtask

  task automatic test_parity_checks;
    apply_settings(16'd2, 16'd1, 16'd2, 16'd1, 8'h5A, 8'hC3, 1'b0);
    do_read(with_check_bits(16'h2B6D));
    do_read(with_check_bits(16'h2B6D) ^ 16'h8000);
    do_read(with_check_bits(16'h2B6D) ^ 16'h4000);
    do_read(with_check_bits(16'h0000));
    write_reg(REG_TWELVE, 16'h0001);
    do_read(with_check_bits(16'h3FFF));
  endtask

  task automatic test_busy_events;
    apply_settings(16'd3, 16'd3, 16'd3, 16'd3, 8'h81, 8'h7E, 1'b0);
    send_event(ACT_START, 8'h01);
    send_event(ACT_START, 8'h02);
    send_event(ACT_BYTE, 8'hA5);
    repeat (3) send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_START, 8'h00);
    send_event(ACT_UNUSED, 8'h3C);
    send_event(ACT_BYTE, 8'h95);
    send_event(ACT_BYTE, 8'h6A);
    finish_read(with_check_bits(16'h156A));
  endtask

  task automatic test_wait_change;
    apply_settings(16'd10, 16'd10, 16'd10, 16'd10, 8'h11, 8'h22, 1'b0);
    send_event(ACT_START, 8'h00);
    repeat (6) send_event(ACT_TICK, 8'h00);
    write_reg(REG_SETUP, 16'd4);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_BYTE, 8'hC0);
    repeat (7) send_event(ACT_TICK, 8'h00);
    write_reg(REG_GAP, 16'd2);
    finish_read(with_check_bits(16'h0001));
  endtask

  task automatic test_receiver_hold;
    apply_settings(16'd2, 16'd2, 16'd2, 16'd2, 8'hF0, 8'h0F, 1'b0);
    hold_requests <= hold_requests + 1;
    repeat (3) do_read(with_check_bits(16'($urandom)));
  endtask

  task automatic test_random_traffic;
    for (int round = 0; round < 4; round++) begin
      idling_on <= (round < 3);
      apply_settings(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(0, 5)), 16'($urandom_range(0, 8)),
                     8'($urandom), 8'($urandom), round[0]);
      for (int n = 0; n < ROUND_EVENTS; n++) random_event();
    end
  endtask

  // widest wait registers, then shortened part way through the wait
  task automatic test_longest_waits;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hA5, 8'h5A, 1'b1);
    send_event(ACT_START, 8'h00);
    repeat (5) send_event(ACT_TICK, 8'h00);
    apply_settings(16'd6, 16'd3, 16'd2, 16'd4, 8'hA5, 8'h5A, 1'b1);
    finish_read(with_check_bits(16'h2AAA));
  endtask

  initial begin
    timing_regs.setup_ticks = SETUP_RST;
    timing_regs.gap_ticks = GAP_RST;
    timing_regs.hold_ticks = HOLD_RST;
    timing_regs.idle_ticks = IDLE_RST;
    timing_regs.first_command = 8'h00;
    timing_regs.second_command = 8'h00;
    timing_regs.twelve_bit_mode = 1'b0;
    read_state = '0;
    read_state.ph = PH_IDLE;
    read_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_settings();
    test_register_extremes();
    test_parity_checks();
    test_busy_events();
    test_wait_change();
    test_receiver_hold();
    test_random_traffic();
    test_longest_waits();
    settle_block();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("PASS encoder_spi_read_sequencer");
    end else begin
      $display("FAIL encoder_spi_read_sequencer");
    end
    $finish;
  end

endmodule
